// ===== rtl/ect_pkg.sv =====
package ect_pkg;

    // fixed field widths
    localparam int TYPE_W    = 4;
    localparam int DATA_W    = 64;
    localparam int TIME_W    = 32;
    localparam int PENDING_W = 5;
    localparam int CMD_W     = 2;

    // parameter defaults
    localparam int DEF_TYPE_COUNT   = 16;
    localparam int DEF_PAYLOAD_BITS = 64;
    localparam int DEF_STAMP_BITS   = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(100);

    typedef enum logic [CMD_W-1:0] {
        CMD_COALESCE  = 2'd0,
        CMD_FLUSH_ONE = 2'd1,
        CMD_FLUSH_ALL = 2'd2,
        CMD_UNUSED    = 2'd3
    } t_cmd;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_NOP,
        OP_COALESCE,
        OP_FLUSH_ONE,
        OP_FLUSH_ALL
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } t_back_state;

    typedef struct packed {
        t_op                op;
        logic [TYPE_W-1:0]  ev_kind;
        logic [DATA_W-1:0]  event_data;
        logic [TIME_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic                 valid;
        logic                 has_event;
        logic [TYPE_W-1:0]    out_type;
        logic [DATA_W-1:0]    out_data;
        logic                 last;
        logic [PENDING_W-1:0] pending_count;
    } t_result;

endpackage

// ===== rtl/ect_front.sv =====
module ect_front import ect_pkg::*; #(
    parameter int TYPE_COUNT = DEF_TYPE_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [TYPE_W-1:0]  i_event_type,
    input  logic [DATA_W-1:0]  i_event_data,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic               i_pop,
    output t_item              o_item,
    output logic               o_item_valid
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL    = FILL_W'(QUEUE_DEPTH);

    t_item              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0]  r_fill;
    logic [PTR_W-1:0]   n_wr_ptr, n_rd_ptr;
    logic [FILL_W-1:0]  n_fill;

    t_item  w_class;
    logic   w_in_table;
    logic   w_push;

    // classify the command
    assign w_in_table = 32'(i_event_type) < TYPE_COUNT;

    always_comb begin
        w_class.ev_kind    = i_event_type;
        w_class.event_data = i_event_data;
        w_class.now_ms     = i_now_ms;
        unique case (t_cmd'(i_cmd))
            CMD_COALESCE:  w_class.op = w_in_table ? OP_COALESCE : OP_NOP;
            CMD_FLUSH_ONE: w_class.op = w_in_table ? OP_FLUSH_ONE : OP_NOP;
            CMD_FLUSH_ALL: w_class.op = OP_FLUSH_ALL;
            default:       w_class.op = OP_NOP;
        endcase
    end

    assign busy         = (r_fill == FULL);
    assign w_push       = start && !busy;
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop && o_item_valid) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !(i_pop && o_item_valid)) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (!w_push && i_pop && o_item_valid) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_class;
        end
    end

endmodule

// ===== rtl/ect_back.sv =====
module ect_back import ect_pkg::*; #(
    parameter int TYPE_COUNT   = DEF_TYPE_COUNT,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int STAMP_BITS   = DEF_STAMP_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [TIME_W-1:0]  i_window,
    input  t_item              i_item,
    input  logic               i_item_valid,
    output logic               o_pop,
    output t_result            o_result
);

    localparam int IDX_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int CNT_W = $clog2(TYPE_COUNT + 1);
    localparam int CMP_W = (STAMP_BITS > TIME_W) ? STAMP_BITS : TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TYPE_COUNT - 1);

    // entry stores
    logic [STAMP_BITS-1:0]   r_stamp_mem [TYPE_COUNT];
    logic [PAYLOAD_BITS-1:0] r_pay_mem   [TYPE_COUNT];
    logic [STAMP_BITS-1:0]   r_rd_stamp;
    logic [PAYLOAD_BITS-1:0] r_rd_payload;

    t_back_state            r_state, n_state;
    t_item                  r_item, n_item;
    logic [TYPE_COUNT-1:0]  r_valid, n_valid;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_remaining, n_remaining;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_idx_q, n_idx_q;
    logic                   r_walk_vld, n_walk_vld;
    t_result                r_res, n_res;

    logic [IDX_W-1:0]        w_rd_idx, w_wr_idx;
    logic                    w_stamp_we, w_pay_we;
    logic [STAMP_BITS-1:0]   w_now_s, w_age;
    logic [PAYLOAD_BITS-1:0] w_new_payload;
    logic                    w_hit, w_expired;

    assign w_wr_idx      = IDX_W'(r_item.ev_kind);
    assign w_now_s       = STAMP_BITS'(r_item.now_ms);
    assign w_new_payload = PAYLOAD_BITS'(r_item.event_data);
    assign w_hit         = r_valid[w_wr_idx];
    assign w_age         = w_now_s - r_rd_stamp;
    assign w_expired     = CMP_W'(w_age) >= CMP_W'(i_window);

    assign o_result = r_res;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_valid     = r_valid;
        n_count     = r_count;
        n_remaining = r_remaining;
        n_idx       = r_idx;
        n_idx_q     = r_idx_q;
        n_walk_vld  = r_walk_vld;
        n_res       = '0;
        o_pop       = 1'b0;
        w_rd_idx    = r_idx;
        w_stamp_we  = 1'b0;
        w_pay_we    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                w_rd_idx = IDX_W'(i_item.ev_kind);
                if (i_item_valid) begin
                    o_pop  = 1'b1;
                    n_item = i_item;
                    if (i_item.op == OP_FLUSH_ALL && r_count != '0) begin
                        n_state     = ST_WALK;
                        n_idx       = '0;
                        n_walk_vld  = 1'b0;
                        n_remaining = r_count;
                        n_count     = '0;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                n_state   = ST_IDLE;
                n_res.valid = 1'b1;
                n_res.last  = 1'b1;
                unique case (r_item.op)
                    OP_COALESCE: begin
                        if (!w_hit) begin
                            n_valid[w_wr_idx] = 1'b1;
                            w_stamp_we = 1'b1;
                            w_pay_we   = 1'b1;
                            n_count    = r_count + CNT_W'(1);
                        end else if (w_expired) begin
                            w_stamp_we = 1'b1;
                            w_pay_we   = 1'b1;
                            n_res.has_event = 1'b1;
                            n_res.out_type  = r_item.ev_kind;
                            n_res.out_data  = DATA_W'(r_rd_payload);
                        end else begin
                            w_pay_we = 1'b1;
                        end
                    end
                    OP_FLUSH_ONE: begin
                        if (w_hit) begin
                            n_valid[w_wr_idx] = 1'b0;
                            n_count = r_count - CNT_W'(1);
                            n_res.has_event = 1'b1;
                            n_res.out_type  = r_item.ev_kind;
                            n_res.out_data  = DATA_W'(r_rd_payload);
                        end
                    end
                    default: begin
                    end
                endcase
                n_res.pending_count = PENDING_W'(n_count);
            end

            ST_WALK: begin
                // read one entry a cycle, test it the cycle after
                n_idx_q    = r_idx;
                n_walk_vld = 1'b1;
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + IDX_W'(1);
                end
                if (r_walk_vld && r_valid[r_idx_q]) begin
                    n_valid[r_idx_q] = 1'b0;
                    n_remaining = r_remaining - CNT_W'(1);
                    n_res.valid         = 1'b1;
                    n_res.has_event     = 1'b1;
                    n_res.out_type      = TYPE_W'(r_idx_q);
                    n_res.out_data      = DATA_W'(r_rd_payload);
                    n_res.last          = (r_remaining == CNT_W'(1));
                    n_res.pending_count = PENDING_W'(r_count);
                    if (r_remaining == CNT_W'(1)) begin
                        n_state    = ST_IDLE;
                        n_walk_vld = 1'b0;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_remaining <= '0;
            r_idx       <= '0;
            r_idx_q     <= '0;
            r_walk_vld  <= 1'b0;
            r_res       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_idx       <= n_idx;
            r_idx_q     <= n_idx_q;
            r_walk_vld  <= n_walk_vld;
            r_res       <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    always_ff @(posedge i_clk) begin
        if (w_stamp_we) begin
            r_stamp_mem[w_wr_idx] <= w_now_s;
        end
        if (w_pay_we) begin
            r_pay_mem[w_wr_idx] <= w_new_payload;
        end
        r_rd_stamp   <= r_stamp_mem[w_rd_idx];
        r_rd_payload <= r_pay_mem[w_rd_idx];
    end

endmodule

// ===== rtl/event_coalescing_table_core.sv =====
// coalesce and flush-one: the table side reads the entry as it pops the command, then checks
// and updates it in the exec state, result strobe registered; the front queue holds two more commands
// flush-all: one entry read per cycle by the table walk
// results cannot be held off by the receiver: one strobe, one beat
// synchronous active-low reset empties the table and queue, window returns to 100 ms
module event_coalescing_table_core import ect_pkg::*; #(
    parameter int TYPE_COUNT   = DEF_TYPE_COUNT,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS,
    parameter int STAMP_BITS   = DEF_STAMP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command side
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [TYPE_W-1:0]     i_event_type,
    input  logic [DATA_W-1:0]     i_event_data,
    input  logic [TIME_W-1:0]     i_now_ms,
    // window register
    input  logic                  i_cfg_we,
    input  logic [TIME_W-1:0]     i_cfg_wdata,
    // result side
    output logic                  o_result_valid,
    output logic                  o_has_event,
    output logic [TYPE_W-1:0]     o_out_type,
    output logic [DATA_W-1:0]     o_out_data,
    output logic                  o_last,
    output logic [PENDING_W-1:0]  o_pending_count
);

    // coalescing window in ms
    logic [TIME_W-1:0] r_window;

    // front to back queue head
    t_item   w_item;
    logic    w_item_valid;
    logic    w_pop;
    t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // front: decodes each command and queues it
    ect_front #(
        .TYPE_COUNT (TYPE_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_event_type (i_event_type),
        .i_event_data (i_event_data),
        .i_now_ms     (i_now_ms),
        .i_pop        (w_pop),
        .o_item       (w_item),
        .o_item_valid (w_item_valid)
    );

    // back: entry read, age check and write, plus the flush-all walk
    ect_back #(
        .TYPE_COUNT   (TYPE_COUNT),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .STAMP_BITS   (STAMP_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_window     (r_window),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_pop        (w_pop),
        .o_result     (w_result)
    );

    // registered result beat straight to the ports
    assign o_result_valid  = w_result.valid;
    assign o_has_event     = w_result.has_event;
    assign o_out_type      = w_result.out_type;
    assign o_out_data      = w_result.out_data;
    assign o_last          = w_result.last;
    assign o_pending_count = w_result.pending_count;

endmodule

// ===== rtl/ect_checker.sv =====
module ect_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_result_valid,
    input logic        o_has_event,
    input logic [3:0]  o_out_type,
    input logic [63:0] o_out_data,
    input logic        o_last,
    input logic [4:0]  o_pending_count
);

    // reset leaves no beat and an empty queue
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid && !busy)
        else $error("result or busy right after reset");

    // an empty result is a single, cleared beat
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_has_event |-> o_last && o_out_type == 4'd0
                                           && o_out_data == 64'd0)
        else $error("no-event beat not cleared");

    // only a flush-all gives non-final beats, and it leaves the table empty
    a_walk_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_last |-> o_has_event && o_pending_count == 5'd0)
        else $error("bad non-final beat");

    // a final beat is never directly followed by another beat: the table side returns to idle first
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last |=> !o_result_valid)
        else $error("beat directly after a final beat");

endmodule

bind event_coalescing_table_core ect_checker u_ect_checker (.*);

// ===== tb/sv/event_coalescing_table_core_test.sv =====
`timescale 1ns / 1ps

module event_coalescing_table_core_test;
    import ect_pkg::*;

    // run length guard and settling time after the last beat
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          SETTLE_SHORT = 4;
    localparam int          SETTLE_LONG  = DEF_TYPE_COUNT + 4;

    // one emitted result as seen on the result ports
    typedef struct {
        logic                 has_event;
        logic [TYPE_W-1:0]    out_type;
        logic [DATA_W-1:0]    out_data;
        logic                 last;
        logic [PENDING_W-1:0] pending_count;
    } t_emit;

    // mirror of the coalescing table plus the queue of emits it predicts
    class coalesce_checker;
        bit                   live [DEF_TYPE_COUNT];
        logic [TIME_W-1:0]    entry_ms [DEF_TYPE_COUNT];
        logic [DATA_W-1:0]    entry_payload [DEF_TYPE_COUNT];
        int unsigned          live_count;
        logic [TIME_W-1:0]    window_len;
        t_emit                expected_emits [$];
        int unsigned          mismatches;

        function new();
            foreach (live[t]) begin
                live[t] = 1'b0;
                entry_ms[t] = '0;
                entry_payload[t] = '0;
            end
            live_count = 0;
            window_len = WINDOW_RESET;
            mismatches = 0;
        endfunction

        function void push_emit(logic has, logic [TYPE_W-1:0] kind,
                                logic [DATA_W-1:0] data, logic is_last);
            t_emit e;
            e.has_event = has;
            e.out_type = kind;
            e.out_data = data;
            e.last = is_last;
            e.pending_count = PENDING_W'(live_count);
            expected_emits = {expected_emits, e};
        endfunction

        // a command beat was accepted: update the table and queue its emits
        function void take_command(t_cmd cmd, logic [TYPE_W-1:0] kind,
                                   logic [DATA_W-1:0] data, logic [TIME_W-1:0] at_ms);
            logic [TIME_W-1:0] age;
            int unsigned       remaining;
            case (cmd)
                CMD_COALESCE: begin
                    if (!live[kind]) begin
                        live[kind] = 1'b1;
                        entry_payload[kind] = data;
                        entry_ms[kind] = at_ms;
                        live_count++;
                        push_emit(1'b0, '0, '0, 1'b1);
                    end else begin
                        age = at_ms - entry_ms[kind];
                        if (age >= window_len) begin
                            push_emit(1'b1, kind, entry_payload[kind], 1'b1);
                            entry_ms[kind] = at_ms;
                        end else begin
                            push_emit(1'b0, '0, '0, 1'b1);
                        end
                        entry_payload[kind] = data;
                    end
                end
                CMD_FLUSH_ONE: begin
                    if (live[kind]) begin
                        live[kind] = 1'b0;
                        live_count--;
                        push_emit(1'b1, kind, entry_payload[kind], 1'b1);
                    end else begin
                        push_emit(1'b0, '0, '0, 1'b1);
                    end
                end
                CMD_FLUSH_ALL: begin
                    if (live_count == 0) begin
                        push_emit(1'b0, '0, '0, 1'b1);
                    end else begin
                        remaining = live_count;
                        live_count = 0;
                        for (int t = 0; t < DEF_TYPE_COUNT; t++) begin
                            if (live[t]) begin
                                live[t] = 1'b0;
                                remaining--;
                                push_emit(1'b1, TYPE_W'(t), entry_payload[t],
                                          remaining == 0);
                            end
                        end
                    end
                end
                default: push_emit(1'b0, '0, '0, 1'b1);
            endcase
        endfunction

        function void check_emit(logic has, logic [TYPE_W-1:0] kind,
                                 logic [DATA_W-1:0] data, logic is_last,
                                 logic [PENDING_W-1:0] pending);
            t_emit e;
            if (expected_emits.size() == 0) begin
                $error("result beat with nothing expected: has_event %0b type %0h data %0h",
                       has, kind, data);
                mismatches++;
                return;
            end
            e = expected_emits.pop_front();
            if (has !== e.has_event) begin
                $error("has_event expected %0h actual %0h", e.has_event, has);
                mismatches++;
            end
            if (kind !== e.out_type) begin
                $error("out_type expected %0h actual %0h", e.out_type, kind);
                mismatches++;
            end
            if (data !== e.out_data) begin
                $error("out_data expected %0h actual %0h", e.out_data, data);
                mismatches++;
            end
            if (is_last !== e.last) begin
                $error("last expected %0h actual %0h", e.last, is_last);
                mismatches++;
            end
            if (pending !== e.pending_count) begin
                $error("pending_count expected %0h actual %0h", e.pending_count, pending);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [CMD_W-1:0]     i_cmd = '0;
    logic [TYPE_W-1:0]    i_event_type = '0;
    logic [DATA_W-1:0]    i_event_data = '0;
    logic [TIME_W-1:0]    i_now_ms = '0;
    logic                 i_cfg_we = 1'b0;
    logic [TIME_W-1:0]    i_cfg_wdata = '0;
    logic                 o_result_valid;
    logic                 o_has_event;
    logic [TYPE_W-1:0]    o_out_type;
    logic [DATA_W-1:0]    o_out_data;
    logic                 o_last;
    logic [PENDING_W-1:0] o_pending_count;

    coalesce_checker   chk = new();
    int unsigned       cycle_count = 0;
    logic [TIME_W-1:0] ms_clock = 32'hFFFF_FF00;  // starts just short of the wrap
    int                burst_left = 0;

    event_coalescing_table_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_event_type    (i_event_type),
        .i_event_data    (i_event_data),
        .i_now_ms        (i_now_ms),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_valid  (o_result_valid),
        .o_has_event     (o_has_event),
        .o_out_type      (o_out_type),
        .o_out_data      (o_out_data),
        .o_last          (o_last),
        .o_pending_count (o_pending_count)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // every result beat lasts one cycle and cannot be stalled, so check it on the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            chk.check_emit(o_has_event, o_out_type, o_out_data, o_last, o_pending_count);
        end
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // idle cycles after a beat: mostly none or a few, now and then a long pause,
    // and occasional stretches of back-to-back beats
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called on a rising edge; returns on the edge that took the beat, or after the gap
    task automatic send_command(t_cmd cmd, logic [TYPE_W-1:0] kind,
                                logic [DATA_W-1:0] data, logic [TIME_W-1:0] at_ms,
                                int gap);
        start <= 1'b1;
        i_cmd <= cmd;
        i_event_type <= kind;
        i_event_data <= data;
        i_now_ms <= at_ms;
        do @(posedge i_clk); while (busy !== 1'b0);
        chk.take_command(cmd, kind, data, at_ms);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the sender off until every predicted beat has shown up
    task automatic drain_results(int settle);
        start <= 1'b0;
        while (chk.expected_emits.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // the window may only change while the table side is idle
    task automatic set_window(logic [TIME_W-1:0] value);
        drain_results(SETTLE_SHORT);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= $urandom;
        chk.window_len = value;
    endtask

    // time stamp for the next beat: mostly a slowly advancing clock, sometimes
    // aimed right at the window edge of a pending type, sometimes a wild jump
    function automatic logic [TIME_W-1:0] pick_now(t_cmd cmd, logic [TYPE_W-1:0] kind);
        int r;
        r = $urandom_range(0, 99);
        if (cmd == CMD_COALESCE && chk.live[kind] && r < 30) begin
            ms_clock = chk.entry_ms[kind] + chk.window_len
                       + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
        end else if (r < 60) begin
            ms_clock = ms_clock + TIME_W'($urandom_range(0, 3));
        end else if (r < 90) begin
            ms_clock = ms_clock + TIME_W'($urandom_range(0, 300));
        end else begin
            ms_clock = $urandom;
        end
        return ms_clock;
    endfunction

    task automatic run_random(int count);
        int                r;
        t_cmd              cmd;
        logic [TYPE_W-1:0] kind;
        logic [DATA_W-1:0] data;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 72)      cmd = CMD_COALESCE;
            else if (r < 86) cmd = CMD_FLUSH_ONE;
            else if (r < 94) cmd = CMD_FLUSH_ALL;
            else             cmd = CMD_UNUSED;
            // a few hot types so that repeats and expiries are common
            kind = ($urandom_range(0, 99) < 60) ? TYPE_W'($urandom_range(0, 3))
                                                : TYPE_W'($urandom_range(0, 15));
            data = {$urandom, $urandom};
            send_command(cmd, kind, data, pick_now(cmd, kind), pick_gap());
            // now and then let everything drain mid-stream
            if ($urandom_range(0, 99) < 3) drain_results(SETTLE_SHORT);
        end
    endtask

    initial begin
        // synchronous reset held low first
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window of 100 ms: empty flushes, unused command, extremes of the
        // payload and the stamp, a repeat just inside and just at the window across
        // the stamp wrap, then a full table emptied by one flush-all
        send_command(CMD_FLUSH_ALL, 4'h0, '0, 32'h0, pick_gap());
        send_command(CMD_FLUSH_ONE, 4'h5, '0, 32'h0, pick_gap());
        send_command(CMD_UNUSED, 4'hF, '1, 32'hFFFF_FFFF, pick_gap());
        send_command(CMD_COALESCE, 4'h0, '1, 32'hFFFF_FFF0, pick_gap());
        send_command(CMD_COALESCE, 4'hF, '0, 32'hFFFF_FFFF, pick_gap());
        send_command(CMD_COALESCE, 4'h0, 64'h0123_4567_89AB_CDEF, 32'h0000_0053, pick_gap());
        send_command(CMD_COALESCE, 4'h0, 64'hA5A5_5A5A_F00F_0FF0, 32'h0000_0054, pick_gap());
        send_command(CMD_COALESCE, 4'hF, 64'h8000_0000_0000_0001, 32'h0000_0062, pick_gap());
        send_command(CMD_FLUSH_ONE, 4'hF, '0, 32'h0000_0070, pick_gap());
        send_command(CMD_FLUSH_ONE, 4'hF, '1, 32'h0000_0071, pick_gap());
        for (int t = 1; t < DEF_TYPE_COUNT; t++) begin
            send_command(CMD_COALESCE, TYPE_W'(t), {$urandom, $urandom},
                         32'h8000_0000 + TIME_W'(t), pick_gap());
        end
        send_command(CMD_FLUSH_ALL, 4'h7, '1, 32'h8000_0100, pick_gap());
        run_random(90);

        // zero window: any repeat of a pending type expires, even at the same stamp
        set_window(32'h0);
        send_command(CMD_COALESCE, 4'h7, {$urandom, $urandom}, 32'h1234_5678, pick_gap());
        send_command(CMD_COALESCE, 4'h7, {$urandom, $urandom}, 32'h1234_5678, pick_gap());
        send_command(CMD_FLUSH_ALL, 4'h0, '0, 32'h1234_5679, pick_gap());
        run_random(90);

        // widest window: only an age of all ones expires
        set_window(32'hFFFF_FFFF);
        send_command(CMD_COALESCE, 4'h3, {$urandom, $urandom}, 32'd10, pick_gap());
        send_command(CMD_COALESCE, 4'h3, {$urandom, $urandom}, 32'd11, pick_gap());
        send_command(CMD_COALESCE, 4'h3, {$urandom, $urandom}, 32'd9, pick_gap());
        send_command(CMD_FLUSH_ONE, 4'h3, '0, 32'd12, pick_gap());
        run_random(90);

        // a short window and a fully random one
        set_window(TIME_W'($urandom_range(1, 2000)));
        run_random(90);
        set_window($urandom);
        run_random(90);

        // let the last flush-all finish walking the table
        drain_results(SETTLE_LONG);
        if (chk.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
